/* rtl/core/idt_pkg.sv */
// Shared field widths and stream layouts for the ID intern table.
package idt_pkg;

  localparam int ID_W           = 32;
  localparam int ENTRY_INDEX_W  = 10;
  localparam int ENTRIES_USED_W = 11;

  // Stream widths; the two data buses are padded to whole bytes.
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 2;

  // Positions of the flags in m_tuser.
  localparam int FOUND_BIT      = 0;
  localparam int FULL_ERROR_BIT = 1;

endpackage

/* rtl/core/idt_store.sv */
// Single-port-write, registered-read memory that holds the interned IDs.
module idt_store #(
  parameter int TABLE_DEPTH = 1024,
  parameter int IW          = 10
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [IW-1:0]           wr_addr,
  input  logic [idt_pkg::ID_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [IW-1:0]           rd_addr,
  output logic [idt_pkg::ID_W-1:0] rd_data
);

  logic [idt_pkg::ID_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/id_intern_table_core.sv */
// Top level of the ID intern table: linear-search sequencer, memory and output register.
// Each input is searched by one memory read per stored entry, pipelined against one
// 32-bit compare; after the last compare the result is loaded into the output register,
// which waits while a held result has not yet been taken with m_tready.
// Throughput: one item at a time; s_tready is high only while the sequencer is idle.
// Reset (rst, synchronous, active high) empties the table and drops any pending result.
module id_intern_table_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [idt_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] id_value
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [idt_pkg::M_TDATA_W-1:0]    m_tdata,   // [9:0] entry_index, [20:10] entries_used
  output logic [idt_pkg::M_TUSER_W-1:0]    m_tuser    // [0] found, [1] full_error
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]               state;
  logic [idt_pkg::ID_W-1:0] key;
  logic [CW-1:0]            count;
  logic [CW-1:0]            rd_ptr;
  logic                     cmp_valid;
  logic [IW-1:0]            cmp_idx;
  logic [IW-1:0]            res_idx;
  logic                     res_found;
  logic                     res_err;
  logic [idt_pkg::ENTRY_INDEX_W-1:0]  out_idx;
  logic [idt_pkg::ENTRIES_USED_W-1:0] out_used;
  logic                     out_found;
  logic                     out_err;

  logic                     issue;
  logic                     hit;
  logic                     room;
  logic                     wr_en;
  logic                     load_out;
  logic [idt_pkg::ID_W-1:0] rd_data;
  logic [31:0]              idx_ext;
  logic [31:0]              used_ext;

  // A read is issued for every stored entry; its data is compared in the following cycle.
  assign issue = (state == ST_SCAN) && (rd_ptr < count);
  assign hit   = cmp_valid && (rd_data == key);
  assign room  = count < DEPTH_C;
  assign wr_en = (state == ST_SCAN) && !issue && !hit && room;

  assign load_out = (state == ST_FINISH) && (!m_tvalid || m_tready);

  idt_store #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IW         (IW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[IW-1:0]),
    .wr_data(key),
    .rd_en  (issue),
    .rd_addr(rd_ptr[IW-1:0]),
    .rd_data(rd_data)
  );

  assign s_tready = (state == ST_IDLE);

  // Wide tables are reported modulo the field widths.
  assign idx_ext  = 32'(res_idx);
  assign used_ext = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            key       <= s_tdata[idt_pkg::ID_W-1:0];
            rd_ptr    <= '0;
            cmp_valid <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_valid <= issue;
          cmp_idx   <= rd_ptr[IW-1:0];
          if (issue) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (hit) begin
            res_idx   <= cmp_idx;
            res_found <= 1'b1;
            res_err   <= 1'b0;
            cmp_valid <= 1'b0;
            state     <= ST_FINISH;
          end else if (!issue) begin
            // Every stored entry has been compared without a match.
            res_found <= 1'b0;
            if (room) begin
              res_idx <= count[IW-1:0];
              res_err <= 1'b0;
              count   <= count + 1'b1;
            end else begin
              res_idx <= '0;
              res_err <= 1'b1;
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (load_out) begin
            out_idx   <= idx_ext[idt_pkg::ENTRY_INDEX_W-1:0];
            out_used  <= used_ext[idt_pkg::ENTRIES_USED_W-1:0];
            out_found <= res_found;
            out_err   <= res_err;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, out_used, out_idx};
  assign m_tuser = {out_err, out_found};

endmodule

/* rtl/core/idt_checker.sv */
// Port-level checks for the ID intern table, bound to the top level.
module idt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [idt_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [idt_pkg::M_TUSER_W-1:0] m_tuser
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A full-table error carries index zero and no found flag.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[idt_pkg::FULL_ERROR_BIT] |->
      m_tdata[idt_pkg::ENTRY_INDEX_W-1:0] == '0 && !m_tuser[idt_pkg::FOUND_BIT])
    else $error("full_error result with nonzero index or found flag");

  // Input is refused right after a transfer, while the search runs.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted during a search");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind id_intern_table_core idt_checker u_idt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
